// ----- rtl/pfd_pkg.sv -----
// Shared types and constants for the filtered-derivative PID controller.
package pfd_pkg;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_KP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KI      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KD      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAU     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX = 3'd6;

  typedef enum logic [2:0] {
    SEL_PROP,
    SEL_KT,
    SEL_INT,
    SEL_D1,
    SEL_D2
  } mul_sel_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_MLO,
    OP_MHI,
    OP_WB,
    OP_INTEG,
    OP_CLAMP,
    OP_ABS,
    OP_SETUP,
    OP_DIV,
    OP_DERIV,
    OP_DRIVE
  } dp_op_t;

  typedef struct packed {
    dp_op_t   op;
    mul_sel_t sel;
  } dp_cmd_t;

endpackage

// ----- rtl/pfd_ctrl.sv -----
// Sequencer that steps the datapath through one item.
module pfd_ctrl #(
  parameter int DATA_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  output pfd_pkg::dp_cmd_t cmd
);
  import pfd_pkg::*;

  localparam int CW = $clog2(DATA_WIDTH);

  typedef enum logic [3:0] {
    S_IDLE, S_MLO, S_MHI, S_WB, S_INTEG, S_CLAMP,
    S_ABS, S_SETUP, S_DIV, S_DERIV, S_DRIVE
  } state_t;

  state_t   state_r;
  mul_sel_t sel_r;
  logic [CW-1:0] cnt_r;
  logic     out_valid_r;
  logic     slot_free;
  mul_sel_t sel_nxt;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    unique case (sel_r)
      SEL_PROP: sel_nxt = SEL_KT;
      SEL_KT:   sel_nxt = SEL_INT;
      SEL_INT:  sel_nxt = SEL_D1;
      SEL_D1:   sel_nxt = SEL_D2;
      default:  sel_nxt = SEL_PROP;
    endcase
  end

  always_comb begin
    cmd.sel = sel_r;
    unique case (state_r)
      S_IDLE:  cmd.op = in_valid ? OP_LOAD : OP_IDLE;
      S_MLO:   cmd.op = OP_MLO;
      S_MHI:   cmd.op = OP_MHI;
      S_WB:    cmd.op = OP_WB;
      S_INTEG: cmd.op = OP_INTEG;
      S_CLAMP: cmd.op = OP_CLAMP;
      S_ABS:   cmd.op = OP_ABS;
      S_SETUP: cmd.op = OP_SETUP;
      S_DIV:   cmd.op = OP_DIV;
      S_DERIV: cmd.op = OP_DERIV;
      S_DRIVE: cmd.op = slot_free ? OP_DRIVE : OP_IDLE;
      default: cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sel_r       <= SEL_PROP;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DRIVE && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            sel_r   <= SEL_PROP;
            state_r <= S_MLO;
          end
        end
        S_MLO: state_r <= S_MHI;
        S_MHI: state_r <= S_WB;
        S_WB: begin
          if (sel_r == SEL_D2) begin
            state_r <= S_INTEG;
          end else begin
            sel_r   <= sel_nxt;
            state_r <= S_MLO;
          end
        end
        S_INTEG: state_r <= S_CLAMP;
        S_CLAMP: state_r <= S_ABS;
        S_ABS:   state_r <= S_SETUP;
        S_SETUP: begin
          cnt_r   <= CW'(DATA_WIDTH - 1);
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (cnt_r == '0) begin
            state_r <= S_DERIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_DERIV: state_r <= S_DRIVE;
        S_DRIVE: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/pfd_dp.sv -----
// Datapath: config registers, shared split multiplier, divider and loop state.
module pfd_dp #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  pfd_pkg::dp_cmd_t               cmd,
  input  logic signed [DATA_WIDTH-1:0]   in_target,
  input  logic signed [DATA_WIDTH-1:0]   in_measured,
  input  logic                           cfg_we,
  input  logic [pfd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [DATA_WIDTH-1:0]          cfg_data,
  output logic signed [DATA_WIDTH-1:0]   out_drive
);
  import pfd_pkg::*;

  localparam int W    = DATA_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int MW   = W + 1;
  localparam int LB   = MW / 2;
  localparam int HB   = MW - LB;
  localparam int PW   = 2 * MW;
  localparam int NW   = 2 * W + 3;
  localparam int MAGW = 2 * W + 4;
  localparam int DW   = W + 1;

  localparam logic signed [W-1:0]  SMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic signed [W-1:0]  SMIN = {1'b1, {(W-1){1'b0}}};
  localparam logic signed [PW-1:0] HALF = PW'(1) << (F - 1);

  // configuration
  logic signed [W-1:0] kp_r, ki_r, kd_r, omin_r, omax_r;
  logic [W-2:0]        per_r, tau_r;

  // loop state
  logic signed [W-1:0] integ_r, dacc_r, lerr_r, lmeas_r;

  // per-item working registers
  logic signed [W-1:0]  meas_r, err_r, prop_r, kt_r, ipart_r, drive_r;
  logic signed [PW-1:0] acc_r;
  logic signed [NW-1:0] num_r;
  logic signed [W:0]    hlim_r, llim_r;
  logic [MAGW-1:0]      mag_r;
  logic                 neg_r, ovf_r;
  logic [DW-1:0]        rem_r;
  logic [W-1:0]         quo_r;

  logic [DW-1:0]          den;
  logic signed [W:0]      dtau;
  logic signed [W:0]      diff;
  logic signed [W-1:0]    err_sat;
  logic signed [MW-1:0]   op_a, op_b;
  logic signed [MW+LB:0]  pp_lo;
  logic signed [MW+HB-1:0] pp_hi;
  logic signed [PW-1:0]   rx, rs;
  logic signed [W-1:0]    rnd;
  logic signed [W:0]      isum;
  logic signed [W-1:0]    isum_sat;
  logic signed [W:0]      integ_x;
  logic [NW-1:0]          anum;
  logic [DW:0]            dv_t;
  logic                   dv_ge;
  logic                   q_big;
  logic signed [W+1:0]    dsum;

  assign den  = DW'({tau_r, 1'b0}) + DW'(per_r);
  assign dtau = $signed({1'b0, tau_r, 1'b0}) - $signed({2'b00, per_r});

  assign diff    = $signed({in_target[W-1], in_target}) - $signed({in_measured[W-1], in_measured});
  assign err_sat = (diff[W] != diff[W-1]) ? (diff[W] ? SMIN : SMAX) : diff[W-1:0];

  always_comb begin
    unique case (cmd.sel)
      SEL_PROP: begin
        op_a = $signed({kp_r[W-1], kp_r});
        op_b = $signed({err_r[W-1], err_r});
      end
      SEL_KT: begin
        op_a = $signed({ki_r[W-1], ki_r});
        op_b = $signed({2'b00, per_r});
      end
      SEL_INT: begin
        op_a = $signed({kt_r[W-1], kt_r});
        op_b = $signed({lerr_r[W-1], lerr_r}) + $signed({err_r[W-1], err_r});
      end
      SEL_D1: begin
        op_a = $signed({kd_r, 1'b0});
        op_b = $signed({meas_r[W-1], meas_r}) - $signed({lmeas_r[W-1], lmeas_r});
      end
      default: begin
        op_a = dtau;
        op_b = $signed({dacc_r[W-1], dacc_r});
      end
    endcase
  end

  // two partial products: low half in the MLO step, high half added in the MHI step
  assign pp_lo = op_a * $signed({1'b0, op_b[LB-1:0]});
  assign pp_hi = op_a * $signed(op_b[MW-1:LB]);

  assign rx  = acc_r + HALF;
  assign rs  = rx >>> F;
  assign rnd = ((&rs[PW-1:W-1]) || !(|rs[PW-1:W-1])) ? rs[W-1:0]
             : (rs[PW-1] ? SMIN : SMAX);

  assign isum     = $signed({integ_r[W-1], integ_r}) + $signed({ipart_r[W-1], ipart_r});
  assign isum_sat = (isum[W] != isum[W-1]) ? (isum[W] ? SMIN : SMAX) : isum[W-1:0];
  assign integ_x  = $signed({integ_r[W-1], integ_r});

  assign anum  = num_r[NW-1] ? NW'(-num_r) : NW'(num_r);
  assign dv_t  = {rem_r, quo_r[W-1]};
  assign dv_ge = (dv_t >= {1'b0, den});
  assign q_big = ovf_r || quo_r[W-1];

  assign dsum = $signed({{2{prop_r[W-1]}}, prop_r}) + $signed({{2{integ_r[W-1]}}, integ_r})
              + $signed({{2{dacc_r[W-1]}}, dacc_r});

  assign out_drive = drive_r;

  // configuration and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= '0;
      ki_r    <= '0;
      kd_r    <= '0;
      per_r   <= (W-1)'(1) << F;
      tau_r   <= '0;
      omin_r  <= '0;
      omax_r  <= '0;
      integ_r <= '0;
      dacc_r  <= '0;
      lerr_r  <= '0;
      lmeas_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KP:      kp_r   <= cfg_data;
          REG_KI:      ki_r   <= cfg_data;
          REG_KD:      kd_r   <= cfg_data;
          REG_PERIOD:  per_r  <= cfg_data[W-2:0];
          REG_TAU:     tau_r  <= cfg_data[W-2:0];
          REG_OUT_MIN: omin_r <= cfg_data;
          REG_OUT_MAX: omax_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_INTEG) begin
        integ_r <= isum_sat;
      end else if (cmd.op == OP_CLAMP) begin
        if (integ_x > hlim_r) begin
          integ_r <= hlim_r[W-1:0];
        end else if (integ_x < llim_r) begin
          integ_r <= llim_r[W-1:0];
        end
      end
      if (cmd.op == OP_DERIV) begin
        if (den == '0) begin
          dacc_r <= '0;
        end else if (neg_r) begin
          dacc_r <= q_big ? SMIN : -$signed(quo_r);
        end else begin
          dacc_r <= q_big ? SMAX : $signed(quo_r);
        end
      end
      if (cmd.op == OP_DRIVE) begin
        lerr_r  <= err_r;
        lmeas_r <= meas_r;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        err_r  <= err_sat;
        meas_r <= in_measured;
      end
      OP_MLO: acc_r <= PW'(pp_lo);
      OP_MHI: acc_r <= acc_r + (PW'(pp_hi) <<< LB);
      OP_WB: begin
        unique case (cmd.sel)
          SEL_PROP: prop_r  <= rnd;
          SEL_KT:   kt_r    <= rnd;
          SEL_INT:  ipart_r <= rnd;
          SEL_D1:   num_r   <= NW'(acc_r);
          default:  num_r   <= num_r + NW'(acc_r);
        endcase
      end
      OP_INTEG: begin
        hlim_r <= (omax_r > prop_r)
                ? $signed({omax_r[W-1], omax_r}) - $signed({prop_r[W-1], prop_r})
                : $signed({omax_r[W-1], omax_r});
        llim_r <= (omin_r < prop_r)
                ? $signed({omin_r[W-1], omin_r}) - $signed({prop_r[W-1], prop_r})
                : $signed({omin_r[W-1], omin_r});
      end
      OP_ABS: begin
        mag_r <= MAGW'(anum) + MAGW'(den >> 1);
        neg_r <= !num_r[NW-1] && (|num_r);
      end
      OP_SETUP: begin
        ovf_r <= (mag_r >= MAGW'({den, {W{1'b0}}}));
        rem_r <= DW'(mag_r >> W);
        quo_r <= mag_r[W-1:0];
      end
      OP_DIV: begin
        rem_r <= dv_ge ? DW'(dv_t - {1'b0, den}) : DW'(dv_t);
        quo_r <= {quo_r[W-2:0], dv_ge};
      end
      OP_DRIVE: begin
        if (dsum > $signed({{2{omax_r[W-1]}}, omax_r})) begin
          drive_r <= omax_r;
        end else if (dsum < $signed({{2{omin_r[W-1]}}, omin_r})) begin
          drive_r <= omin_r;
        end else begin
          drive_r <= dsum[W-1:0];
        end
      end
      default: ;
    endcase
  end

endmodule

// ----- rtl/pid_controller_filtered_derivative.sv -----
// Top level of the PID controller with a band-limited derivative on the measurement.
//
//  channel | handshake                   | payload
//  --------+-----------------------------+-----------------------------------
//  in      | in_valid / in_stall         | in_target, in_measured (signed)
//  out     | out_valid / out_stall       | out_drive (signed)
//  cfg     | cfg_valid / cfg_ready       | cfg_index, cfg_data
//
// Each item runs five products on one shared split multiplier, each as a
// low-half, high-half and write-back step, then a restoring divider
// that retires one quotient bit a cycle for the derivative filter.
// Reset clears the gains, limits and loop state; sample period resets to 1.0.
// A finished item waits in the output register while the next item is taken;
// the sequencer holds at its last step only while that register is still full.
// cfg_ready is always high; write registers only while the block is idle.
module pid_controller_filtered_derivative #(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [DATA_WIDTH-1:0]  in_target,
  input  logic signed [DATA_WIDTH-1:0]  in_measured,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [DATA_WIDTH-1:0]  out_drive,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [pfd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_WIDTH-1:0]         cfg_data
);
  import pfd_pkg::*;

  dp_cmd_t cmd;

  // config writes are never held off and go straight into the registers
  assign cfg_ready = 1'b1;

  pfd_ctrl #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  pfd_dp #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_target  (in_target),
    .in_measured(in_measured),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_drive  (out_drive)
  );

  // an accepted item keeps the sequencer busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken again right after an accept");

  // a new result appears only as the sequencer returns to idle
  a_result_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (!in_stall && $past(in_stall)))
    else $error("result raised outside the end of an item");

endmodule

// ----- tb/pid_controller_filtered_derivative_tb.sv -----
// Testbench for the filtered-derivative PID controller: directed and random stimulus checked against a predictor.
`timescale 1ns / 1ps

module pid_controller_filtered_derivative_tb;
  import pfd_pkg::*;

  localparam int DW = 32;
  localparam int FB = 16;
  // Index past the register file; the block must drop writes to it.
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam logic signed [127:0] VMAX = 128'sh7fffffff;
  localparam logic signed [127:0] VMIN = -VMAX - 1;

  // Predictor and store of expected drive values.
  class drive_scoreboard;
    logic signed [127:0] kp, ki, kd, period, tau, lim_lo, lim_hi;
    logic signed [127:0] integ, deriv, prev_err, prev_meas;
    logic [DW-1:0] pending[$];
    int errors;

    function new();
      kp = 0; ki = 0; kd = 0; period = 65536; tau = 0; lim_lo = 0; lim_hi = 0;
      integ = 0; deriv = 0; prev_err = 0; prev_meas = 0; errors = 0;
    endfunction

    function logic signed [127:0] clip(logic signed [127:0] x);
      if (x > VMAX) return VMAX;
      if (x < VMIN) return VMIN;
      return x;
    endfunction

    // Exact product, round half up at FB fractional bits, saturate.
    function logic signed [127:0] qmul(logic signed [127:0] a, logic signed [127:0] b);
      logic signed [127:0] x;
      x = a * b + (128'sd1 <<< (FB - 1));
      return clip(x >>> FB);
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [DW-1:0] data);
      logic signed [DW-1:0] sd;
      sd = data;
      case (idx)
        REG_KP:      kp = sd;
        REG_KI:      ki = sd;
        REG_KD:      kd = sd;
        REG_PERIOD:  period = {97'd0, data[30:0]};
        REG_TAU:     tau = {97'd0, data[30:0]};
        REG_OUT_MIN: lim_lo = sd;
        REG_OUT_MAX: lim_hi = sd;
        default: ;
      endcase
    endfunction

    function void note_input(logic signed [DW-1:0] tgt, logic signed [DW-1:0] meas);
      logic signed [127:0] t, m, e, p, kt, hi, lo, den, num, mg, q, drv;
      t = tgt;
      m = meas;
      e = clip(t - m);
      p = qmul(kp, e);
      kt = qmul(ki, period);
      integ = clip(integ + qmul(kt, e + prev_err));
      hi = lim_hi;
      lo = lim_lo;
      if (lim_hi > p) hi = lim_hi - p;
      if (lim_lo < p) lo = lim_lo - p;
      // Narrowed anti-windup clamp: upper bound wins.
      if (integ > hi) integ = hi;
      else if (integ < lo) integ = lo;
      den = 2 * tau + period;
      if (den == 0) begin
        deriv = 0;
      end else begin
        num = -((2 * kd) * (m - prev_meas) + (2 * tau - period) * deriv);
        mg = (num < 0) ? -num : num;
        q = (mg + (den >>> 1)) / den;
        if (num < 0) q = -q;
        deriv = clip(q);
      end
      drv = p + integ + deriv;
      if (drv > lim_hi) drv = lim_hi;
      else if (drv < lim_lo) drv = lim_lo;
      prev_err = e;
      prev_meas = m;
      pending.push_back(drv[DW-1:0]);
    endfunction

    function void check(logic [DW-1:0] drive);
      logic [DW-1:0] want;
      if (pending.size() == 0) begin
        $error("unexpected drive item %h", drive);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (want !== drive) begin
        $error("drive mismatch: expected %h actual %h", want, drive);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall, cfg_valid, cfg_ready;
  logic signed [DW-1:0] in_target, in_measured, out_drive;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [DW-1:0] cfg_data;

  drive_scoreboard sb;
  bit quiet;       // no idling on either side
  bit hold_req;    // ask the receiver for one long hold-off
  logic signed [DW-1:0] walk_meas;

  pid_controller_filtered_derivative #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_target(in_target), .in_measured(in_measured),
    .out_valid(out_valid), .out_stall(out_stall), .out_drive(out_drive),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop for a hung run.
  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(15, 50);
  endfunction

  // Receiver: check every accepted item, then pick the next stall.
  initial begin : receiver
    int hold;
    hold = 0;
    out_stall = 1'b1;
    @(posedge clk);
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) sb.check(out_drive);
      if (hold_req) begin
        hold_req = 1'b0;
        hold = 400;
      end
      if (hold > 0) begin
        hold--;
        out_stall <= 1'b1;
      end else if (gap_len() > 0) begin
        hold = gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Offer one item after a random gap; hold it until accepted.
  task automatic send_item(input logic [DW-1:0] tgt, input logic [DW-1:0] meas);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_target   <= tgt;
    in_measured <= meas;
    do @(posedge clk); while (in_stall);
    sb.note_input(tgt, meas);
  endtask

  // Drop valid, wait for every expected item, then let the sequencer settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0;
      3: return $urandom();
      default: return $urandom_range(0, 32'h3_ffff) - 32'h2_0000;
    endcase
  endfunction

  function automatic logic [DW-1:0] pick_time();
    case ($urandom_range(0, 4))
      0: return 32'h7fff_ffff;
      1: return 32'h1;
      2: return $urandom() & 32'h7fff_ffff;
      default: return $urandom_range(1, 32'h2_0000);
    endcase
  endfunction

  task automatic random_config();
    logic [DW-1:0] a, b;
    write_reg(REG_KP, pick_value());
    write_reg(REG_KI, pick_value());
    write_reg(REG_KD, pick_value());
    write_reg(REG_PERIOD, pick_time());
    // Tau may be zero as well.
    write_reg(REG_TAU, ($urandom_range(0, 3) == 0) ? 32'h0 : pick_time());
    a = pick_value();
    b = pick_value();
    // Mostly ordered limits; sometimes leave them inverted.
    if ($urandom_range(0, 3) != 0 && $signed(a) > $signed(b)) begin
      write_reg(REG_OUT_MIN, b);
      write_reg(REG_OUT_MAX, a);
    end else begin
      write_reg(REG_OUT_MIN, a);
      write_reg(REG_OUT_MAX, b);
    end
  endtask

  // Mostly a slowly moving plant around a setpoint; the rest full-range noise.
  task automatic random_item();
    logic [DW-1:0] tgt;
    if ($urandom_range(0, 9) < 7) begin
      tgt = $urandom_range(0, 32'h64_0000) - 32'h32_0000;
      walk_meas = walk_meas + ($urandom_range(0, 32'h2_0000) - 32'h1_0000);
      send_item(tgt, walk_meas);
    end else begin
      send_item($urandom(), $urandom());
    end
  endtask

  initial begin : stimulus
    logic [DW-1:0] ext[4];
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target = '0;
    in_measured = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    walk_meas = '0;
    ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'h0001_0000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: a couple of items on reset settings, then moderate gains.
    send_item(32'h0001_0000, 32'h0);
    send_item(32'h0, 32'h0001_0000);
    drain();
    write_reg(REG_KP, 32'h0001_0000);
    write_reg(REG_KI, 32'h0000_8000);
    write_reg(REG_KD, 32'h0000_4000);
    write_reg(REG_PERIOD, 32'h0000_1000);
    write_reg(REG_TAU, 32'h0000_8000);
    write_reg(REG_OUT_MIN, 32'hff9c_0000);
    write_reg(REG_OUT_MAX, 32'h0064_0000);
    write_reg(REG_UNUSED, 32'hdead_beef);
    // Field extremes, including error saturation both ways.
    foreach (ext[i]) foreach (ext[j]) send_item(ext[i], ext[j]);
    // Hold the error so the integrator runs into its narrowed clamp.
    repeat (4) send_item(32'h0050_0000, 32'h0);
    drain();

    // Inverted limits, zero tau with the longest period, extreme gains.
    write_reg(REG_OUT_MIN, 32'h0010_0000);
    write_reg(REG_OUT_MAX, 32'hfff0_0000);
    write_reg(REG_TAU, 32'h0);
    write_reg(REG_PERIOD, 32'h7fff_ffff);
    write_reg(REG_KP, 32'h7fff_ffff);
    write_reg(REG_KI, 32'h8000_0000);
    write_reg(REG_KD, 32'h7fff_ffff);
    send_item(32'h7fff_ffff, 32'h8000_0000);
    send_item(32'h8000_0000, 32'h7fff_ffff);
    send_item(32'h0, 32'h0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      random_config();
      quiet = (ph == 4);
      if (ph == 2) hold_req = 1'b1;
      repeat (70) random_item();
      drain();
    end
    quiet = 1'b0;

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/pfd_pkg.sv
rtl/pfd_ctrl.sv
rtl/pfd_dp.sv
rtl/pid_controller_filtered_derivative.sv
tb/pid_controller_filtered_derivative_tb.sv
